@@ rtl/tgs_pkg.sv @@
// Package for the two-vocabulary topic Gibbs sampler.
// Holds state encodings, register indexes and fixed widths; depends on nothing.
package tgs_pkg;

   // fixed field and datapath widths
   localparam int TOPIC_W     = 6;
   localparam int K_W         = 7;
   localparam int TOPIC_CAP   = 64;
   localparam int CUM_AW      = 6;
   localparam int WEIGHT_W    = 48;
   localparam int SUM_W       = 64;
   localparam int TOTAL_W     = 32;
   localparam int RND_W       = 32;
   localparam int MUL_CHUNK   = 16;
   localparam int STEP_W      = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PRIOR_W     = 16;
   localparam int VSIZE_W     = 13;
   localparam int VB_W        = 29;
   localparam int DOC_W       = 10;
   localparam int WORD_W      = 12;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_TOPICS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA_FIRST  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA_SECOND = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VSIZE_FIRST = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VSIZE_SECOND= 3'd5;

   // register reset values
   localparam logic [K_W-1:0]     RST_NUM_TOPICS = 7'd64;
   localparam logic [PRIOR_W-1:0] RST_ALPHA      = 16'd128;
   localparam logic [PRIOR_W-1:0] RST_BETA       = 16'd26;
   localparam logic [VSIZE_W-1:0] RST_VSIZE      = 13'd4096;

   // operations
   localparam logic OP_ASSIGN   = 1'b0;
   localparam logic OP_RESAMPLE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DEC_RD,
      ST_DEC_WR,
      ST_LOOP_RD,
      ST_LOOP_PREP,
      ST_LOOP_WAIT,
      ST_THR_HI,
      ST_THR_LO,
      ST_THR_ADD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_INC_RD,
      ST_INC_WR,
      ST_RESULT
   } tgs_state_type;

   typedef enum logic [2:0] {
      WU_IDLE,
      WU_MUL,
      WU_CHECK,
      WU_DIV,
      WU_DONE
   } wu_state_type;

endpackage

@@ rtl/tgs_weight_unit.sv @@
// Per-topic weight unit: floor(a*b/d) saturated to 48 bits.
// Chunked multiplier then restoring divider, one quotient bit a cycle; uses tgs_pkg.
module tgs_weight_unit #(
   parameter int A_W = 33,
   parameter int B_W = 33,
   parameter int D_W = 41
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [A_W-1:0]                a,
   input  logic [B_W-1:0]                b,
   input  logic [D_W-1:0]                d,
   output logic [tgs_pkg::WEIGHT_W-1:0]  weight,
   output logic                          done
);

   localparam int CH    = tgs_pkg::MUL_CHUNK;
   localparam int NCH   = (B_W + CH - 1) / CH;
   localparam int BP_W  = NCH * CH;
   localparam int P_W   = A_W + B_W;
   localparam int QW    = tgs_pkg::WEIGHT_W;
   localparam int PE_W  = (P_W > QW) ? P_W : QW + 1;
   localparam int HI_W  = PE_W - QW;
   localparam int CMP_W = HI_W + D_W;
   localparam int SW    = tgs_pkg::STEP_W;

   tgs_pkg::wu_state_type state_ff, state_in;

   logic [A_W-1:0]    a_ff;
   logic [BP_W-1:0]   bsh_ff;
   logic [D_W-1:0]    d_ff;
   logic [PE_W-1:0]   prod_ff;
   logic [D_W-1:0]    rem_ff;
   logic [QW-1:0]     low_ff;
   logic [QW-1:0]     q_ff;
   logic [SW-1:0]     step_ff;

   logic [A_W+CH-1:0] part;
   logic [HI_W-1:0]   hi;
   logic              sat;
   logic [D_W:0]      cand;
   logic [D_W:0]      diff;
   logic              fits;
   logic              last_mul;
   logic              last_div;

   // partial product, saturation test and divider step
   assign part     = (A_W+CH)'(a_ff) * (A_W+CH)'(bsh_ff[BP_W-1 -: CH]);
   assign hi       = prod_ff[PE_W-1:QW];
   assign sat      = CMP_W'(hi) >= CMP_W'(d_ff);
   assign cand     = {rem_ff, low_ff[QW-1]};
   assign fits     = cand >= {1'b0, d_ff};
   assign diff     = cand - {1'b0, d_ff};
   assign last_mul = step_ff == SW'(NCH - 1);
   assign last_div = step_ff == SW'(QW - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tgs_pkg::WU_IDLE:  if (start) state_in = tgs_pkg::WU_MUL;
         tgs_pkg::WU_MUL:   if (last_mul) state_in = tgs_pkg::WU_CHECK;
         tgs_pkg::WU_CHECK: state_in = sat ? tgs_pkg::WU_DONE : tgs_pkg::WU_DIV;
         tgs_pkg::WU_DIV:   if (last_div) state_in = tgs_pkg::WU_DONE;
         tgs_pkg::WU_DONE:  state_in = tgs_pkg::WU_IDLE;
         default:           state_in = tgs_pkg::WU_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done   = state_ff == tgs_pkg::WU_DONE;
      weight = q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgs_pkg::WU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         tgs_pkg::WU_IDLE: begin
            if (start) begin
               a_ff    <= a;
               bsh_ff  <= BP_W'(b);
               d_ff    <= d;
               prod_ff <= '0;
               step_ff <= '0;
            end
         end
         tgs_pkg::WU_MUL: begin
            prod_ff <= (prod_ff << CH) + PE_W'(part);
            bsh_ff  <= bsh_ff << CH;
            step_ff <= step_ff + 1'b1;
         end
         tgs_pkg::WU_CHECK: begin
            // quotient at or above 2^48 (or zero divisor) saturates
            if (sat) begin
               q_ff <= '1;
            end else begin
               q_ff <= '0;
            end
            rem_ff  <= D_W'(hi);
            low_ff  <= prod_ff[QW-1:0];
            step_ff <= '0;
         end
         tgs_pkg::WU_DIV: begin
            rem_ff  <= fits ? D_W'(diff) : D_W'(cand);
            q_ff    <= {q_ff[QW-2:0], fits};
            low_ff  <= low_ff << 1;
            step_ff <= step_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/topic_gibbs_sampler_two_vocab.sv @@
// Two-vocabulary collapsed Gibbs topic sampler, one transaction at a time.
// An assignment checks, reads and increments the counts; a resample also removes the old
// count, runs the weight unit once per topic over K topics, scales the total and scans.
// A new request is taken only in idle; a result waits in the output register.
// Reset: synchronous; a clearing pass over max(MAX_DOCS,MAX_VOCAB)*MAX_TOPICS entries zeroes
// the count memories, during which no request is taken. Uses tgs_pkg, tgs_weight_unit.
module topic_gibbs_sampler_two_vocab #(
   parameter int MAX_TOPICS = 64,
   parameter int MAX_DOCS   = 1024,
   parameter int MAX_VOCAB  = 4096,
   parameter int COUNT_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [tgs_pkg::DOC_W-1:0]          req_doc_index,
   input  logic [tgs_pkg::WORD_W-1:0]         req_word_index,
   input  logic                               req_vocab_select,
   input  logic [tgs_pkg::TOPIC_W-1:0]        req_current_topic,
   input  logic [tgs_pkg::RND_W-1:0]          req_random_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tgs_pkg::TOPIC_W-1:0]        rsp_new_topic,
   output logic                               rsp_topic_error,
   input  logic                               csr_write,
   input  logic [tgs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tgs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int TW         = $clog2(MAX_TOPICS);
   localparam int DOC_DEPTH  = MAX_DOCS * MAX_TOPICS;
   localparam int WORD_DEPTH = MAX_VOCAB * MAX_TOPICS;
   localparam int DAW        = $clog2(DOC_DEPTH);
   localparam int WAW        = $clog2(WORD_DEPTH);
   localparam int CLR_DEPTH  = (DOC_DEPTH > WORD_DEPTH) ? DOC_DEPTH : WORD_DEPTH;
   localparam int CLR_AW     = $clog2(CLR_DEPTH);
   localparam int K_LIMIT    = (MAX_TOPICS < tgs_pkg::TOPIC_CAP) ? MAX_TOPICS
                                                                 : tgs_pkg::TOPIC_CAP;
   localparam int A_W        = COUNT_BITS + 9;
   localparam int D_W        = tgs_pkg::TOTAL_W + 9;
   localparam int KW         = tgs_pkg::K_W;
   localparam int SUMW       = tgs_pkg::SUM_W;
   localparam int TOTW       = tgs_pkg::TOTAL_W;

   // count memories
   logic [COUNT_BITS-1:0] doc_mem [DOC_DEPTH];
   logic [COUNT_BITS-1:0] w1_mem  [WORD_DEPTH];
   logic [COUNT_BITS-1:0] w2_mem  [WORD_DEPTH];
   logic [TOTW-1:0]       t1_mem  [MAX_TOPICS];
   logic [TOTW-1:0]       t2_mem  [MAX_TOPICS];
   logic [SUMW-1:0]       cum_mem [tgs_pkg::TOPIC_CAP];

   logic [COUNT_BITS-1:0] doc_q_ff, w1_q_ff, w2_q_ff;
   logic [TOTW-1:0]       t1_q_ff, t2_q_ff;
   logic [SUMW-1:0]       cum_q_ff;

   tgs_pkg::tgs_state_type state_ff, state_in;
   logic [CLR_AW-1:0]      clr_ff;

   // configuration
   logic [KW-1:0]                   num_topics_ff;
   logic [tgs_pkg::PRIOR_W-1:0]     alpha_ff, beta1_ff, beta2_ff;
   logic [tgs_pkg::VSIZE_W-1:0]     vsize1_ff, vsize2_ff;

   // transaction fields
   logic                            op_ff;
   logic [tgs_pkg::DOC_W-1:0]       doc_ff;
   logic [tgs_pkg::WORD_W-1:0]      word_ff;
   logic                            sel_ff;
   logic [tgs_pkg::TOPIC_W-1:0]     cur_ff;
   logic [tgs_pkg::RND_W-1:0]       rnd_ff;
   logic [KW-1:0]                   k_ff, k_in;
   logic [tgs_pkg::PRIOR_W-1:0]     beta_ff;
   logic [tgs_pkg::VB_W-1:0]        vb_ff;

   // working registers
   logic [KW-1:0]                   loop_ff, pick_ff;
   logic [SUMW-1:0]                 sum_ff, thr_hi_ff, thr_lo_ff, thr_ff;
   logic [tgs_pkg::TOPIC_W-1:0]     res_topic_ff;
   logic                            res_err_ff;
   logic                            rsp_valid_ff;
   logic [tgs_pkg::TOPIC_W-1:0]     rsp_new_topic_ff;
   logic                            rsp_topic_error_ff;

   // control
   logic                  accept;
   logic                  clr_last;
   logic                  loop_last;
   logic                  out_free;
   logic                  idx_bad;
   logic                  doc_we, w1_we, w2_we, t1_we, t2_we, cum_we, wu_start;
   logic [KW-1:0]         topic_sel;
   logic [DAW-1:0]        doc_addr;
   logic [WAW-1:0]        word_addr;
   logic [TW-1:0]         tot_addr;
   logic [COUNT_BITS-1:0] word_q, doc_wd, word_wd;
   logic [TOTW-1:0]       tot_q, tot_wd;
   logic [A_W-1:0]        wu_a, wu_b;
   logic [D_W-1:0]        wu_d;
   logic [tgs_pkg::WEIGHT_W-1:0] wu_weight;
   logic                  wu_done;
   logic [SUMW-1:0]       sum_next;
   logic [SUMW-1:0]       thr_prod;
   logic [31:0]           thr_op;
   logic [tgs_pkg::VB_W-1:0] vb_in;

   assign accept    = req_valid && !req_stall;
   assign clr_last  = clr_ff == CLR_AW'(CLR_DEPTH - 1);
   assign loop_last = loop_ff == (k_ff - 1'b1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_bad   = (32'(doc_ff) >= MAX_DOCS) || (32'(word_ff) >= MAX_VOCAB);
   assign word_q    = sel_ff ? w2_q_ff : w1_q_ff;
   assign tot_q     = sel_ff ? t2_q_ff : t1_q_ff;
   assign sum_next  = sum_ff + SUMW'(wu_weight);

   // topic count in use, clamped
   always_comb begin
      if (num_topics_ff == '0) begin
         k_in = KW'(1);
      end else if (num_topics_ff > KW'(K_LIMIT)) begin
         k_in = KW'(K_LIMIT);
      end else begin
         k_in = num_topics_ff;
      end
   end

   assign vb_in = req_vocab_select
                ? tgs_pkg::VB_W'(vsize2_ff) * tgs_pkg::VB_W'(beta2_ff)
                : tgs_pkg::VB_W'(vsize1_ff) * tgs_pkg::VB_W'(beta1_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tgs_pkg::ST_CLEAR:     if (clr_last) state_in = tgs_pkg::ST_IDLE;
         tgs_pkg::ST_IDLE:      if (accept) state_in = tgs_pkg::ST_CHECK;
         tgs_pkg::ST_CHECK: begin
            if (KW'(cur_ff) >= k_ff || idx_bad) begin
               state_in = tgs_pkg::ST_RESULT;
            end else if (op_ff == tgs_pkg::OP_ASSIGN) begin
               state_in = tgs_pkg::ST_INC_RD;
            end else begin
               state_in = tgs_pkg::ST_DEC_RD;
            end
         end
         tgs_pkg::ST_DEC_RD:    state_in = tgs_pkg::ST_DEC_WR;
         tgs_pkg::ST_DEC_WR:    state_in = tgs_pkg::ST_LOOP_RD;
         tgs_pkg::ST_LOOP_RD:   state_in = tgs_pkg::ST_LOOP_PREP;
         tgs_pkg::ST_LOOP_PREP: state_in = tgs_pkg::ST_LOOP_WAIT;
         tgs_pkg::ST_LOOP_WAIT: begin
            if (wu_done) begin
               state_in = loop_last ? tgs_pkg::ST_THR_HI : tgs_pkg::ST_LOOP_RD;
            end
         end
         tgs_pkg::ST_THR_HI:    state_in = tgs_pkg::ST_THR_LO;
         tgs_pkg::ST_THR_LO:    state_in = tgs_pkg::ST_THR_ADD;
         tgs_pkg::ST_THR_ADD:   state_in = tgs_pkg::ST_SCAN_RD;
         tgs_pkg::ST_SCAN_RD:   state_in = tgs_pkg::ST_SCAN_CMP;
         tgs_pkg::ST_SCAN_CMP: begin
            if (cum_q_ff > thr_ff || loop_last) begin
               state_in = tgs_pkg::ST_INC_RD;
            end else begin
               state_in = tgs_pkg::ST_SCAN_RD;
            end
         end
         tgs_pkg::ST_INC_RD:    state_in = tgs_pkg::ST_INC_WR;
         tgs_pkg::ST_INC_WR:    state_in = tgs_pkg::ST_RESULT;
         tgs_pkg::ST_RESULT:    if (out_free) state_in = tgs_pkg::ST_IDLE;
         default:               state_in = tgs_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = state_ff != tgs_pkg::ST_IDLE;
      doc_we    = 1'b0;
      w1_we     = 1'b0;
      w2_we     = 1'b0;
      t1_we     = 1'b0;
      t2_we     = 1'b0;
      cum_we    = 1'b0;
      wu_start  = 1'b0;
      case (state_ff)
         tgs_pkg::ST_CLEAR: begin
            doc_we = 32'(clr_ff) < DOC_DEPTH;
            w1_we  = 32'(clr_ff) < WORD_DEPTH;
            w2_we  = 32'(clr_ff) < WORD_DEPTH;
            t1_we  = 32'(clr_ff) < MAX_TOPICS;
            t2_we  = 32'(clr_ff) < MAX_TOPICS;
         end
         tgs_pkg::ST_DEC_WR, tgs_pkg::ST_INC_WR: begin
            doc_we = 1'b1;
            w1_we  = !sel_ff;
            w2_we  = sel_ff;
            t1_we  = !sel_ff;
            t2_we  = sel_ff;
         end
         tgs_pkg::ST_LOOP_PREP: wu_start = 1'b1;
         tgs_pkg::ST_LOOP_WAIT: cum_we = wu_done;
         default: begin
         end
      endcase
   end

   // memory addressing and write data
   always_comb begin
      case (state_ff)
         tgs_pkg::ST_DEC_RD, tgs_pkg::ST_DEC_WR: topic_sel = KW'(cur_ff);
         tgs_pkg::ST_INC_RD, tgs_pkg::ST_INC_WR: topic_sel = pick_ff;
         default:                                topic_sel = loop_ff;
      endcase
      if (state_ff == tgs_pkg::ST_CLEAR) begin
         doc_addr  = DAW'(clr_ff);
         word_addr = WAW'(clr_ff);
         tot_addr  = TW'(clr_ff);
         doc_wd    = '0;
         word_wd   = '0;
         tot_wd    = '0;
      end else begin
         doc_addr  = DAW'(doc_ff) * DAW'(MAX_TOPICS) + DAW'(topic_sel);
         word_addr = WAW'(word_ff) * WAW'(MAX_TOPICS) + WAW'(topic_sel);
         tot_addr  = TW'(topic_sel);
         if (state_ff == tgs_pkg::ST_DEC_WR) begin
            // removal stops at zero
            doc_wd  = (doc_q_ff == '0) ? doc_q_ff : doc_q_ff - 1'b1;
            word_wd = (word_q == '0) ? word_q : word_q - 1'b1;
            tot_wd  = (tot_q == '0) ? tot_q : tot_q - 1'b1;
         end else begin
            // addition stops at the counter maximum
            doc_wd  = (doc_q_ff == '1) ? doc_q_ff : doc_q_ff + 1'b1;
            word_wd = (word_q == '1) ? word_q : word_q + 1'b1;
            tot_wd  = (tot_q == '1) ? tot_q : tot_q + 1'b1;
         end
      end
   end

   // memories: one write and one registered read a cycle each
   always_ff @(posedge clock) begin
      if (doc_we) doc_mem[doc_addr] <= doc_wd;
      doc_q_ff <= doc_mem[doc_addr];
   end

   always_ff @(posedge clock) begin
      if (w1_we) w1_mem[word_addr] <= word_wd;
      w1_q_ff <= w1_mem[word_addr];
   end

   always_ff @(posedge clock) begin
      if (w2_we) w2_mem[word_addr] <= word_wd;
      w2_q_ff <= w2_mem[word_addr];
   end

   always_ff @(posedge clock) begin
      if (t1_we) t1_mem[tot_addr] <= tot_wd;
      t1_q_ff <= t1_mem[tot_addr];
   end

   always_ff @(posedge clock) begin
      if (t2_we) t2_mem[tot_addr] <= tot_wd;
      t2_q_ff <= t2_mem[tot_addr];
   end

   always_ff @(posedge clock) begin
      if (cum_we) cum_mem[loop_ff[tgs_pkg::CUM_AW-1:0]] <= sum_next;
      cum_q_ff <= cum_mem[loop_ff[tgs_pkg::CUM_AW-1:0]];
   end

   // weight operands from the counts just read
   assign wu_a = A_W'({doc_q_ff, 8'h00}) + A_W'(alpha_ff);
   assign wu_b = A_W'({word_q, 8'h00}) + A_W'(beta_ff);
   assign wu_d = D_W'({tot_q, 8'h00}) + D_W'(vb_ff);

   tgs_weight_unit #(
      .A_W (A_W),
      .B_W (A_W),
      .D_W (D_W)
   ) u_weight (
      .clock  (clock),
      .reset  (reset),
      .start  (wu_start),
      .a      (wu_a),
      .b      (wu_b),
      .d      (wu_d),
      .weight (wu_weight),
      .done   (wu_done)
   );

   // threshold multiplier, high then low half of the total
   assign thr_op   = (state_ff == tgs_pkg::ST_THR_HI) ? sum_ff[63:32] : sum_ff[31:0];
   assign thr_prod = {32'h0, thr_op} * {32'h0, rnd_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tgs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tgs_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == tgs_pkg::ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_topics_ff <= tgs_pkg::RST_NUM_TOPICS;
         alpha_ff      <= tgs_pkg::RST_ALPHA;
         beta1_ff      <= tgs_pkg::RST_BETA;
         beta2_ff      <= tgs_pkg::RST_BETA;
         vsize1_ff     <= tgs_pkg::RST_VSIZE;
         vsize2_ff     <= tgs_pkg::RST_VSIZE;
      end else if (csr_write) begin
         case (csr_index)
            tgs_pkg::CSR_NUM_TOPICS:   num_topics_ff <= csr_wdata[KW-1:0];
            tgs_pkg::CSR_ALPHA:        alpha_ff      <= csr_wdata;
            tgs_pkg::CSR_BETA_FIRST:   beta1_ff      <= csr_wdata;
            tgs_pkg::CSR_BETA_SECOND:  beta2_ff      <= csr_wdata;
            tgs_pkg::CSR_VSIZE_FIRST:  vsize1_ff     <= csr_wdata[tgs_pkg::VSIZE_W-1:0];
            tgs_pkg::CSR_VSIZE_SECOND: vsize2_ff     <= csr_wdata[tgs_pkg::VSIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // transaction datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         tgs_pkg::ST_IDLE: begin
            if (accept) begin
               op_ff   <= req_operation;
               doc_ff  <= req_doc_index;
               word_ff <= req_word_index;
               sel_ff  <= req_vocab_select;
               cur_ff  <= req_current_topic;
               rnd_ff  <= req_random_value;
               k_ff    <= k_in;
               beta_ff <= req_vocab_select ? beta2_ff : beta1_ff;
               vb_ff   <= vb_in;
            end
         end
         tgs_pkg::ST_CHECK: begin
            pick_ff      <= KW'(cur_ff);
            sum_ff       <= '0;
            res_topic_ff <= cur_ff;
            res_err_ff   <= KW'(cur_ff) >= k_ff;
         end
         tgs_pkg::ST_DEC_WR: loop_ff <= '0;
         tgs_pkg::ST_LOOP_WAIT: begin
            if (wu_done) begin
               sum_ff <= sum_next;
               if (!loop_last) loop_ff <= loop_ff + 1'b1;
            end
         end
         tgs_pkg::ST_THR_HI: thr_hi_ff <= thr_prod;
         tgs_pkg::ST_THR_LO: thr_lo_ff <= thr_prod;
         tgs_pkg::ST_THR_ADD: begin
            thr_ff  <= thr_hi_ff + {32'h0, thr_lo_ff[63:32]};
            loop_ff <= '0;
         end
         tgs_pkg::ST_SCAN_CMP: begin
            // first running sum above threshold, else the last topic
            if (cum_q_ff > thr_ff || loop_last) begin
               pick_ff <= loop_ff;
            end else begin
               loop_ff <= loop_ff + 1'b1;
            end
         end
         tgs_pkg::ST_INC_WR: begin
            res_topic_ff <= pick_ff[tgs_pkg::TOPIC_W-1:0];
            res_err_ff   <= 1'b0;
         end
         tgs_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_new_topic_ff   <= res_topic_ff;
               rsp_topic_error_ff <= res_err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_topic   = rsp_new_topic_ff;
   assign rsp_topic_error = rsp_topic_error_ff;

   // checks
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == tgs_pkg::ST_CLEAR |-> !rsp_valid_ff)
      else $error("response raised during clearing pass");

   a_dec_only_resample: assert property (@(posedge clock) disable iff (reset)
      state_ff == tgs_pkg::ST_DEC_WR |-> op_ff == tgs_pkg::OP_RESAMPLE)
      else $error("count removal on an assignment transaction");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == tgs_pkg::ST_SCAN_CMP |-> loop_ff < k_ff)
      else $error("scan ran past the last topic");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == tgs_pkg::ST_INC_RD |-> pick_ff < k_ff)
      else $error("picked topic out of range");

   a_err_keeps_topic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tgs_pkg::ST_RESULT && res_err_ff) |-> res_topic_ff == cur_ff)
      else $error("error result changed the topic");

endmodule
